[rtl/bb3_pkg.sv]
// bb3_pkg: shared types, register indexes and rounding constants of the 3x3 RGB box blur.
// No dependencies; every other file of the block imports it.
package bb3_pkg;

   localparam int CH_W         = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int SUM_W        = 12;   // nine 8-bit values
   localparam int NUMER_W      = 13;   // 2*sum + count
   localparam int RECIP_W      = 18;
   localparam int RECIP_SHIFT  = 18;
   localparam int PROD_W       = NUMER_W + RECIP_W;
   localparam int COUNT_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   // window rows top..bottom, columns left..right
   typedef rgb_type [2:0][2:0] win_type;

   // per-item decisions taken when the transaction is accepted
   typedef struct packed {
      logic emit;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } flags_type;

   // ceil(2^18 / (2*n)); exact floor division for numerators below 4600
   function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd5:    m = 18'd26215;
         4'd6:    m = 18'd21846;
         4'd7:    m = 18'd18725;
         4'd8:    m = 18'd16384;
         4'd9:    m = 18'd14564;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

[rtl/bb3_ctrl.sv]
// bb3_ctrl: frame size registers, input and output position counters, per-item flags.
// Depends on bb3_pkg.
module bb3_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               acc,
   output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
   output bb3_pkg::flags_type                 flags
);
   import bb3_pkg::*;

   localparam int CBITS = $clog2(MAX_WIDTH);
   localparam int WBITS = $clog2(MAX_WIDTH + 1);
   localparam int OBITS = $clog2(MAX_HEIGHT);
   localparam int HBITS = $clog2(MAX_HEIGHT + 1);
   localparam int RBITS = $clog2(MAX_HEIGHT + 2);

   logic [WBITS-1:0] width_ff, width_in, width_cfg;
   logic [HBITS-1:0] height_ff, height_in, height_cfg;
   logic [CBITS-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RBITS-1:0] in_row_ff, in_row_in;
   logic [OBITS-1:0] out_row_ff, out_row_in;
   logic [WIDTH_REG_W-1:0]  wv;
   logic [HEIGHT_REG_W-1:0] hv;
   logic col_end, ocol_end, orow_end, emit;

   assign wv = csr_wdata[WIDTH_REG_W-1:0];
   assign hv = csr_wdata[HEIGHT_REG_W-1:0];

   always_comb begin
      if (wv == '0) begin
         width_cfg = WBITS'(1);
      end else if (32'(wv) > 32'(MAX_WIDTH)) begin
         width_cfg = WBITS'(MAX_WIDTH);
      end else begin
         width_cfg = WBITS'(wv);
      end
      if (hv == '0) begin
         height_cfg = HBITS'(1);
      end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
         height_cfg = HBITS'(MAX_HEIGHT);
      end else begin
         height_cfg = HBITS'(hv);
      end
   end

   assign col_end  = (WBITS'(in_col_ff) + WBITS'(1)) >= width_ff;
   assign ocol_end = (WBITS'(out_col_ff) + WBITS'(1)) >= width_ff;
   assign orow_end = (HBITS'(out_row_ff) + HBITS'(1)) >= height_ff;
   // first result once the window centre sits on pixel (0,0)
   assign emit     = (in_row_ff >= RBITS'(2)) || (in_row_ff == RBITS'(1) && in_col_ff != '0);

   assign rd_addr      = in_col_ff;
   assign flags.emit   = emit;
   assign flags.top    = out_row_ff != '0;
   assign flags.bottom = !orow_end;
   assign flags.left   = out_col_ff != '0;
   assign flags.right  = !ocol_end;
   assign flags.last   = emit && orow_end && ocol_end;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      priority if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = width_cfg;
            CSR_FRAME_HEIGHT: height_in = height_cfg;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (acc) begin
         if (flags.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (col_end) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RBITS'(1);
            end else begin
               in_col_in = in_col_ff + CBITS'(1);
            end
            if (emit) begin
               if (ocol_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OBITS'(1);
               end else begin
                  out_col_in = out_col_ff + CBITS'(1);
               end
            end
         end
      end else begin
         // nothing accepted: counters hold
         in_col_in = in_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WBITS'(1);
         height_ff  <= HBITS'(1);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      WBITS'(in_col_ff) < width_ff)
      else $error("input column beyond frame width");

   a_out_pos_range: assert property (@(posedge clock) disable iff (reset)
      (WBITS'(out_col_ff) < width_ff) && (HBITS'(out_row_ff) < height_ff))
      else $error("output position outside frame");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (acc && flags.last) |=>
         (in_row_ff == '0 && in_col_ff == '0 && out_row_ff == '0 && out_col_ff == '0))
      else $error("counters not cleared after last pixel");

endmodule

[rtl/bb3_line_buf.sv]
// bb3_line_buf: two line memories (registered read), same-address forwarding and 3x3 window.
// Depends on bb3_pkg.
module bb3_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          acc,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  bb3_pkg::rgb_type              px_in,
   input  bb3_pkg::flags_type            flags_in,
   output logic                          win_valid,
   output bb3_pkg::flags_type            win_flags,
   output bb3_pkg::win_type              win
);
   import bb3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   rgb_type older_mem  [MAX_WIDTH];
   rgb_type recent_mem [MAX_WIDTH];

   rgb_type   older_rd_ff, recent_rd_ff;
   rgb_type   fwd_older_ff, fwd_recent_ff;
   logic      s1_fwd_ff;
   logic      s1_valid_ff;
   rgb_type   s1_px_ff;
   logic [AW-1:0] s1_addr_ff;
   flags_type s1_flags_ff;
   logic      s2_valid_ff;
   flags_type s2_flags_ff;
   win_type   win_ff;
   rgb_type   col0, col1;
   logic      wr_en;

   // the item in stage one writes at the same edge the next one reads
   assign col0  = s1_fwd_ff ? fwd_older_ff  : older_rd_ff;
   assign col1  = s1_fwd_ff ? fwd_recent_ff : recent_rd_ff;
   assign wr_en = adv && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[s1_addr_ff] <= col1;
      end
      if (acc) begin
         older_rd_ff <= older_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         recent_mem[s1_addr_ff] <= s1_px_ff;
      end
      if (acc) begin
         recent_rd_ff <= recent_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_px_ff      <= px_in;
         s1_addr_ff    <= rd_addr;
         s1_flags_ff   <= flags_in;
         s1_fwd_ff     <= s1_valid_ff && (s1_addr_ff == rd_addr);
         fwd_older_ff  <= col1;
         fwd_recent_ff <= s1_px_ff;
      end
      if (wr_en) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= col0;
         win_ff[1][2] <= col1;
         win_ff[2][2] <= s1_px_ff;
      end
      if (adv) begin
         s2_flags_ff <= s1_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
         s2_valid_ff <= s1_valid_ff && s1_flags_ff.emit;
      end
   end

   assign win_valid = s2_valid_ff;
   assign win_flags = s2_flags_ff;
   assign win       = win_ff;

endmodule

[rtl/bb3_mean.sv]
// bb3_mean: masked 3x3 sums, reciprocal multiply and rounded per-channel mean.
// Depends on bb3_pkg.
module bb3_mean (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                win_valid,
   input  bb3_pkg::flags_type  win_flags,
   input  bb3_pkg::win_type    win,
   output logic                res_valid,
   output bb3_pkg::rgb_type    res_px,
   output logic                res_last
);
   import bb3_pkg::*;

   function automatic logic [CH_W-1:0] chan(input rgb_type p, input logic [1:0] k);
      logic [CH_W-1:0] v;
      case (k)
         2'd0:    v = p.red;
         2'd1:    v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

   logic [2:0]          row_ok, col_ok;
   logic [1:0]          rows, cols;
   logic [COUNT_W-1:0]  count_in;
   logic [SUM_W-1:0]    sum_in   [3];
   logic [SUM_W-1:0]    row_sum  [3][3];
   logic [NUMER_W-1:0]  numer    [3];

   logic                s3_valid_ff, s3_last_ff;
   logic [SUM_W-1:0]    s3_sum_ff [3];
   logic [COUNT_W-1:0]  s3_count_ff;
   logic                s4_valid_ff, s4_last_ff;
   logic [PROD_W-1:0]   s4_prod_ff [3];

   always_comb begin
      row_ok = {win_flags.bottom, 1'b1, win_flags.top};
      col_ok = {win_flags.right, 1'b1, win_flags.left};
      rows   = 2'd1 + 2'(win_flags.top) + 2'(win_flags.bottom);
      cols   = 2'd1 + 2'(win_flags.left) + 2'(win_flags.right);
      count_in = COUNT_W'(rows) * COUNT_W'(cols);
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            row_sum[k][i] = '0;
            for (int j = 0; j < 3; j++) begin
               if (row_ok[i] && col_ok[j]) begin
                  row_sum[k][i] = row_sum[k][i] + SUM_W'(chan(win[i][j], 2'(k)));
               end
            end
         end
         sum_in[k] = row_sum[k][0] + row_sum[k][1] + row_sum[k][2];
      end
   end

   // (2*sum + count) / (2*count) as a multiply by a rounded-up reciprocal
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         numer[k] = (NUMER_W'(s3_sum_ff[k]) << 1) + NUMER_W'(s3_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sum_ff   <= sum_in;
         s3_count_ff <= count_in;
         s3_last_ff  <= win_flags.last;
         for (int k = 0; k < 3; k++) begin
            s4_prod_ff[k] <= PROD_W'(numer[k]) * PROD_W'(recip_of(s3_count_ff));
         end
         s4_last_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= win_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign res_valid    = s4_valid_ff;
   assign res_last     = s4_last_ff;
   assign res_px.red   = s4_prod_ff[0][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
   assign res_px.green = s4_prod_ff[1][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
   assign res_px.blue  = s4_prod_ff[2][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_count_ff == 4'd1 || s3_count_ff == 4'd2 || s3_count_ff == 4'd3 ||
                       s3_count_ff == 4'd4 || s3_count_ff == 4'd6 || s3_count_ff == 4'd9))
      else $error("neighbourhood count not a product of row and column counts");

endmodule

[rtl/box_blur_3x3_rgb.sv]
// box_blur_3x3_rgb: top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_ctrl, bb3_line_buf and bb3_mean.
//
// Usage
//   req_*  : pixels of one frame in raster order, valid/ready. req_mode flush (1) acts as
//            a black pixel and is used to drain the tail of the frame.
//   rsp_*  : rounded 3x3 means per channel, raster order, valid/ready. rsp_last_pixel marks
//            the bottom-right pixel; the next transaction then starts a new frame.
//   csr_*  : write-only frame_width (index 0) and frame_height (index 1); a write restarts
//            the frame and must only happen while the block is idle.
//   Results lag the input by frame_width+1 transactions: after the frame's pixels, send
//   frame_width+1 flush transactions. A transaction that yields a result shows it on
//   rsp_valid after the line memory read at the accepting edge and then the window,
//   sum, multiply and output registers.
//   Throughput is one transaction per clock while no held result stalls the pipeline;
//   the line memories are read and written back once per transaction, with the write of
//   one transaction forwarded to the next when both address the same column.
//   When the receiver stalls, a held result stops the pipeline only if another result is
//   queued right behind it; otherwise input keeps flowing.
//   Synchronous reset sets both dimensions to 1 and clears all counters; line memory
//   contents are left as they are.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [bb3_pkg::CH_W-1:0]        req_in_red,
   input  logic [bb3_pkg::CH_W-1:0]        req_in_green,
   input  logic [bb3_pkg::CH_W-1:0]        req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bb3_pkg::CH_W-1:0]        rsp_out_red,
   output logic [bb3_pkg::CH_W-1:0]        rsp_out_green,
   output logic [bb3_pkg::CH_W-1:0]        rsp_out_blue,
   output logic                            rsp_last_pixel,
   input  logic                            csr_wr_en,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bb3_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic          adv, acc;
   logic [AW-1:0] rd_addr;
   flags_type     flags;
   rgb_type       px_in;
   logic          win_valid;
   flags_type     win_flags;
   win_type       win;
   logic          res_valid, res_last;
   rgb_type       res_px;
   logic          rsp_valid_ff, rsp_last_ff;
   rgb_type       rsp_px_ff;
   logic          out_load;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   // only a real result behind a held one stalls the pipeline
   assign adv       = out_load || !res_valid;
   assign req_ready = adv;
   assign acc       = req_valid && adv;
   assign px_in     = (req_mode == MODE_FLUSH) ? '0 : {req_in_red, req_in_green, req_in_blue};

   bb3_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .acc       (acc),
      .rd_addr   (rd_addr),
      .flags     (flags)
   );

   bb3_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .acc       (acc),
      .rd_addr   (rd_addr),
      .px_in     (px_in),
      .flags_in  (flags),
      .win_valid (win_valid),
      .win_flags (win_flags),
      .win       (win)
   );

   bb3_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .win_valid (win_valid),
      .win_flags (win_flags),
      .win       (win),
      .res_valid (res_valid),
      .res_px    (res_px),
      .res_last  (res_last)
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_px_ff   <= res_px;
         rsp_last_ff <= res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= res_valid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_px_ff.red;
   assign rsp_out_green  = rsp_px_ff.green;
   assign rsp_out_blue   = rsp_px_ff.blue;
   assign rsp_last_pixel = rsp_last_ff;

endmodule
